// File: rtl/core/xcfe_pkg.sv
package xcfe_pkg;

    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] START_BYTE = 8'hFE;

    // operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] function_code;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       last_of_run;
        logic       status;
    } t_out_item;

    typedef struct packed {
        logic        frame_open;
        logic [15:0] bytes_remaining;
        logic [7:0]  running_checksum;
    } t_frame_state;

endpackage

// File: rtl/core/xcfe_build.sv
// Turns one input item plus the current frame state into its full list of
// result beats (in transmit order) and the next frame state.
module xcfe_build (
    input  xcfe_pkg::t_in_item                            i_item,
    input  xcfe_pkg::t_frame_state                        i_state,
    output xcfe_pkg::t_out_item [xcfe_pkg::MAX_RESULTS-1:0] o_results,
    output logic [xcfe_pkg::CNT_W-1:0]                    o_count,
    output xcfe_pkg::t_frame_state                        o_state
);

    logic [7:0]  hdr_sum;
    logic [15:0] rem_dec;
    logic [7:0]  pay_sum;
    logic        empty_frame;

    assign hdr_sum = xcfe_pkg::START_BYTE
                   ^ i_item.function_code[15:8] ^ i_item.function_code[7:0]
                   ^ i_item.payload_length[15:8] ^ i_item.payload_length[7:0];
    assign empty_frame = (i_item.payload_length == 16'd0);
    assign rem_dec     = i_state.bytes_remaining - 16'd1;
    assign pay_sum     = i_state.running_checksum ^ i_item.data_byte;

    always_comb begin
        o_results = '0;
        o_count   = '0;
        o_state   = i_state;
        if (i_item.operation == xcfe_pkg::OP_START) begin
            o_results[0].out_byte = xcfe_pkg::START_BYTE;
            o_results[1].out_byte = i_item.function_code[15:8];
            o_results[2].out_byte = i_item.function_code[7:0];
            o_results[3].out_byte = i_item.payload_length[15:8];
            o_results[4].out_byte = i_item.payload_length[7:0];
            if (empty_frame) begin
                // header then checksum straight away, frame never opens
                o_results[5].out_byte    = hdr_sum;
                o_results[5].frame_end   = 1'b1;
                o_results[5].last_of_run = 1'b1;
                o_count                  = xcfe_pkg::CNT_W'(6);
                o_state                  = '0;
            end else begin
                o_results[4].last_of_run = 1'b1;
                o_count                  = xcfe_pkg::CNT_W'(5);
                o_state.frame_open       = 1'b1;
                o_state.bytes_remaining  = i_item.payload_length;
                o_state.running_checksum = hdr_sum;
            end
        end else if (!i_state.frame_open) begin
            o_results[0].status      = xcfe_pkg::STATUS_NO_FRAME;
            o_results[0].last_of_run = 1'b1;
            o_count                  = xcfe_pkg::CNT_W'(1);
        end else if (rem_dec == 16'd0) begin
            o_results[0].out_byte    = i_item.data_byte;
            o_results[1].out_byte    = pay_sum;
            o_results[1].frame_end   = 1'b1;
            o_results[1].last_of_run = 1'b1;
            o_count                  = xcfe_pkg::CNT_W'(2);
            o_state                  = '0;
        end else begin
            o_results[0].out_byte    = i_item.data_byte;
            o_results[0].last_of_run = 1'b1;
            o_count                  = xcfe_pkg::CNT_W'(1);
            o_state.bytes_remaining  = rem_dec;
            o_state.running_checksum = pay_sum;
        end
    end

endmodule

// File: rtl/core/xor_checksum_frame_encoder.sv
// Frame encoder: a start beat (function code + payload length) emits 0xFE,
// function code hi/lo and length hi/lo, seeding an XOR checksum; each
// payload beat is passed through and folded in, and the checksum byte closes
// the frame after the last payload byte (or right after the header when the
// length is zero). A payload beat with no open frame gives one status=1
// beat. A new start abandons any open frame without its checksum. Each
// input beat is expanded into a shift buffer of up to six result beats,
// which drain one per cycle into the output register unless the receiver
// stalls. Non-closing payload beats are likewise taken one per cycle; a
// start beat holds the buffer until its five result beats (six for an
// empty frame) drain, so the output port then sets the input rate at one
// result beat per cycle. o_valid rises as the first beat enters r_out.
module xor_checksum_frame_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  xcfe_pkg::t_in_item  i_item,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output xcfe_pkg::t_out_item o_item
);

    // frame state, updated when an input beat is accepted
    xcfe_pkg::t_frame_state r_state;
    xcfe_pkg::t_frame_state n_state;

    // expanded result list for the beat in flight; entry 0 leaves next
    xcfe_pkg::t_out_item [xcfe_pkg::MAX_RESULTS-1:0] n_results;
    xcfe_pkg::t_out_item                            r_buf [xcfe_pkg::MAX_RESULTS];
    logic [xcfe_pkg::CNT_W-1:0]                     r_cnt;
    logic [xcfe_pkg::CNT_W-1:0]                     n_cnt;

    // output register
    xcfe_pkg::t_out_item r_out;
    logic                r_ovalid;

    logic in_accept;
    logic buf_move;

    xcfe_build u_build (
        .i_item    (i_item),
        .i_state   (r_state),
        .o_results (n_results),
        .o_count   (n_cnt),
        .o_state   (n_state)
    );

    // head of buffer advances when the output register is free or draining
    assign buf_move  = (r_cnt != '0) && (!r_ovalid || !i_stall);
    // take a new beat once the buffer is empty or its last beat is leaving
    assign o_stall   = (r_cnt > xcfe_pkg::CNT_W'(1))
                    || ((r_cnt == xcfe_pkg::CNT_W'(1)) && !buf_move);
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
            end else if (buf_move) begin
                r_cnt <= r_cnt - xcfe_pkg::CNT_W'(1);
            end

            if (buf_move) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int i = 0; i < xcfe_pkg::MAX_RESULTS; i++) begin
                r_buf[i] <= n_results[i];
            end
        end else if (buf_move) begin
            for (int i = 0; i < xcfe_pkg::MAX_RESULTS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
        if (buf_move) begin
            r_out <= r_buf[0];
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // closed frame holds no leftover count or checksum
    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.frame_open |-> (r_state.bytes_remaining == 16'd0)
                             && (r_state.running_checksum == 8'd0))
        else $error("closed frame with stale state");

    // an open frame always expects at least one more payload byte
    a_open_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.frame_open |-> (r_state.bytes_remaining != 16'd0))
        else $error("open frame with zero bytes remaining");

    // every accepted beat yields at least one result
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_cnt != '0))
        else $error("accepted beat produced no results");

    // buffer never holds more than one beat's worth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= xcfe_pkg::CNT_W'(xcfe_pkg::MAX_RESULTS))
        else $error("result buffer overflow");

    // checksum and error beats always close their input beat's run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.frame_end || o_item.status) |-> o_item.last_of_run)
        else $error("frame end or error not marked last of run");

endmodule

// File: tb/xor_checksum_frame_encoder_test.sv
`timescale 1ns / 100ps

module xor_checksum_frame_encoder_test;

    localparam int IDLE_LIMIT  = 1000;  // cycles with no beat on either side
    localparam int SETTLE_WAIT = 20;    // quiet cycles after the last result
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    xcfe_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    xcfe_pkg::t_out_item o_item;

    xor_checksum_frame_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Framer mirror: tracks the open frame and queues the bytes each
    // accepted input beat must produce, in transmit order.
    // ------------------------------------------------------------------
    logic                frame_is_open = 1'b0;
    logic [15:0]         payload_left  = '0;
    logic [7:0]          xor_acc       = '0;
    xcfe_pkg::t_out_item expected_bytes[$];

    int          mismatch_count = 0;
    int          beats_sent     = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b0;
    bit          pressure_done  = 1'b0;
    t_stall_mode stall_mode     = STALL_NONE;
    logic [15:0] stall_pattern  = '0;
    logic [3:0]  stall_phase    = '0;
    int          idle_cycles    = 0;

    function automatic void queue_byte(logic [7:0] b, logic fend, logic last, logic st);
        xcfe_pkg::t_out_item r;
        r.out_byte    = b;
        r.frame_end   = fend;
        r.last_of_run = last;
        r.status      = st;
        expected_bytes.push_back(r);
    endfunction

    function automatic void predict_frame_bytes(xcfe_pkg::t_in_item beat);
        logic [7:0] hdr[5];
        logic [7:0] sum;
        logic       empty;
        sum = '0;
        if (beat.operation == xcfe_pkg::OP_START) begin
            // header goes out whole; a frame already open is dropped silently
            empty  = (beat.payload_length == 16'd0);
            hdr[0] = xcfe_pkg::START_BYTE;
            hdr[1] = beat.function_code[15:8];
            hdr[2] = beat.function_code[7:0];
            hdr[3] = beat.payload_length[15:8];
            hdr[4] = beat.payload_length[7:0];
            for (int i = 0; i < 5; i++) begin
                sum ^= hdr[i];
                queue_byte(hdr[i], 1'b0, !empty && i == 4, xcfe_pkg::STATUS_OK);
            end
            if (empty) begin
                // zero length: checksum follows the header directly
                queue_byte(sum, 1'b1, 1'b1, xcfe_pkg::STATUS_OK);
                frame_is_open = 1'b0;
                payload_left  = '0;
                xor_acc       = '0;
            end else begin
                frame_is_open = 1'b1;
                payload_left  = beat.payload_length;
                xor_acc       = sum;
            end
        end else if (!frame_is_open) begin
            // stray payload: error beat, state untouched
            queue_byte(8'h00, 1'b0, 1'b1, xcfe_pkg::STATUS_NO_FRAME);
        end else begin
            xor_acc ^= beat.data_byte;
            payload_left -= 16'd1;
            if (payload_left == 16'd0) begin
                queue_byte(beat.data_byte, 1'b0, 1'b0, xcfe_pkg::STATUS_OK);
                queue_byte(xor_acc, 1'b1, 1'b1, xcfe_pkg::STATUS_OK);
                frame_is_open = 1'b0;
                xor_acc       = '0;
            end else begin
                queue_byte(beat.data_byte, 1'b0, 1'b1, xcfe_pkg::STATUS_OK);
            end
        end
    endfunction

    function automatic void log_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Result side: receiver stall generator, result checker, watchdog.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (stall_mode)
            STALL_RANDOM: begin
                i_stall = ($urandom_range(0, 3) == 0);
            end
            STALL_PATTERN: begin
                i_stall     = stall_pattern[stall_phase];
                stall_phase = stall_phase + 4'd1;
            end
            default: begin
                i_stall = 1'b0;
            end
        endcase
    end

    always @(posedge i_clk) begin : check_results
        xcfe_pkg::t_out_item want;
        logic                bad;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                log_failure($sformatf("unexpected beat: byte=%02h end=%0b last=%0b status=%0b",
                                      o_item.out_byte, o_item.frame_end,
                                      o_item.last_of_run, o_item.status));
            end else begin
                want = expected_bytes.pop_front();
                bad  = (o_item.out_byte    !== want.out_byte)
                    || (o_item.frame_end   !== want.frame_end)
                    || (o_item.last_of_run !== want.last_of_run)
                    || (o_item.status      !== want.status);
                if (bad)
                    log_failure($sformatf({"mismatch: exp byte=%02h end=%0b last=%0b status=%0b",
                                           " / got byte=%02h end=%0b last=%0b status=%0b"},
                                          want.out_byte, want.frame_end,
                                          want.last_of_run, want.status,
                                          o_item.out_byte, o_item.frame_end,
                                          o_item.last_of_run, o_item.status));
            end
        end
        // watchdog: any beat on either channel counts as progress
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One input beat; called at a falling edge, returns at a falling edge.
    // Valid stays high between back-to-back beats.
    task automatic send_beat(xcfe_pkg::t_in_item beat);
        if (gaps_on && burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid = 1'b1;
        i_item  = beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_frame_bytes(beat);
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic xcfe_pkg::t_in_item random_beat(logic op);
        xcfe_pkg::t_in_item b;
        b.operation      = op;
        b.function_code  = 16'($urandom_range(0, 65535));
        b.payload_length = 16'($urandom_range(0, 65535));
        b.data_byte      = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_start(logic [15:0] fcode, logic [15:0] len);
        xcfe_pkg::t_in_item b;
        b                = random_beat(xcfe_pkg::OP_START);
        b.function_code  = fcode;
        b.payload_length = len;
        send_beat(b);
    endtask

    task automatic send_payload(logic [7:0] data);
        xcfe_pkg::t_in_item b;
        b           = random_beat(xcfe_pkg::OP_PAYLOAD);
        b.data_byte = data;
        send_beat(b);
    endtask

    task automatic wait_for_results();
        i_valid = 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
    endtask

    // Mostly well-formed frames; with allow_broken, some are truncated,
    // abandoned with a huge length, or replaced by a stray payload beat.
    task automatic send_random_frame(bit allow_broken);
        int kind;
        int len;
        int sent;
        kind = allow_broken ? $urandom_range(0, 9) : 9;
        case (kind)
            0: begin
                send_beat(random_beat(xcfe_pkg::OP_PAYLOAD));
            end
            1: begin
                send_beat(random_beat(xcfe_pkg::OP_START));
                repeat ($urandom_range(0, 3)) send_beat(random_beat(xcfe_pkg::OP_PAYLOAD));
            end
            2: begin
                len  = $urandom_range(2, 6);
                sent = $urandom_range(1, len - 1);
                send_start(16'($urandom_range(0, 65535)), 16'(len));
                repeat (sent) send_beat(random_beat(xcfe_pkg::OP_PAYLOAD));
            end
            default: begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(0, 6);
                send_start(16'($urandom_range(0, 65535)), 16'(len));
                repeat (len) send_beat(random_beat(xcfe_pkg::OP_PAYLOAD));
            end
        endcase
    endtask

    function automatic void pick_stall_pattern();
        stall_pattern    = 16'($urandom_range(0, 65535));
        stall_pattern[0] = 1'b0;    // keeps every stall run finite
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_stray_payload();
        send_payload(8'hFF);
        send_payload(8'h00);
    endtask

    task automatic test_empty_frames();
        stall_mode = STALL_RANDOM;
        send_start(16'hFFFF, 16'h0000);
        send_start(16'h0000, 16'h0000);
    endtask

    task automatic test_short_frame();
        send_start(16'h1234, 16'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'hA5);
        send_payload(8'h77);        // frame already closed
    endtask

    task automatic test_abandoned_frame();
        pick_stall_pattern();
        stall_mode = STALL_PATTERN;
        send_start(16'h8001, 16'hFFFF);
        send_payload(8'h5A);
        send_payload(8'hC3);
        send_start(16'hABCD, 16'd1);    // drops the open frame
        send_payload(8'h3C);
        send_start(16'h00FF, 16'd1);
        send_payload(8'h81);
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        int start_count;
        gaps_on     = 1'b0;
        stall_mode  = STALL_NONE;
        start_count = beats_sent;
        while (beats_sent - start_count < 25)
            send_random_frame(1'b1);
    endtask

    task automatic test_random_traffic();
        int start_count;
        gaps_on     = 1'b1;
        start_count = beats_sent;
        while (beats_sent - start_count < 65) begin
            if ($urandom_range(0, 5) == 0) begin
                pick_stall_pattern();
                stall_mode = t_stall_mode'($urandom_range(0, 2));
            end
            send_random_frame(1'b1);
            if (!pressure_done && beats_sent - start_count >= 40) begin
                wait_for_results();
                pressure_done = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_stray_payload();
        test_empty_frames();
        test_short_frame();
        test_abandoned_frame();
        test_back_to_back();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_WAIT) @(negedge i_clk);
        while (expected_bytes.size() != 0) begin
            void'(expected_bytes.pop_front());
            log_failure("expected beat never arrived");
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
